[hw/rtl/bcs_pkg.sv]
// Package for the byte class set: set size constants, opcodes, payload structs
// and small bitmap helper functions. No dependencies.
package bcs_pkg;

    localparam int SET_SIZE = 256;
    localparam int LIMIT    = (SET_SIZE > 256) ? 256 : SET_SIZE;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 3;
    localparam int WORD_W   = 8;
    localparam int WORDS    = 256 / WORD_W;
    localparam int IDX_W    = $clog2(WORDS);
    localparam int COUNT_W  = 9;

    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_RANGE    = 3'd2,
        OP_CLEAR    = 3'd3,
        OP_FILL     = 3'd4,
        OP_TEST     = 3'd5,
        OP_COUNT    = 3'd6,
        OP_NEXT_RUN = 3'd7
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] byte_value;
        logic [BYTE_W-1:0] range_high;
    } t_in_item;

    typedef struct packed {
        logic               member;
        logic [COUNT_W-1:0] member_count;
        logic               run_found;
        logic [BYTE_W-1:0]  run_low;
        logic [BYTE_W-1:0]  run_high;
    } t_out_item;

    // Bits of word idx that stand for bytes below the set size.
    function automatic logic [WORD_W-1:0] lim_mask(input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int k = 0; k < WORD_W; k++) begin
            m[k] = ({1'b0, idx, POS_W'(k)} < COUNT_W'(LIMIT));
        end
        return m;
    endfunction

    function automatic logic [POS_W:0] popcount(input logic [WORD_W-1:0] w);
        logic [POS_W:0] c;
        c = '0;
        for (int k = 0; k < WORD_W; k++) begin
            c = c + (POS_W+1)'(w[k]);
        end
        return c;
    endfunction

    // Index of the lowest set bit; 0 when none is set.
    function automatic logic [POS_W-1:0] lowest(input logic [WORD_W-1:0] w);
        logic [POS_W-1:0] p;
        p = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (w[k]) begin
                p = POS_W'(k);
            end
        end
        return p;
    endfunction

endpackage

[hw/rtl/byte_class_set_with_run_search.sv]
// Byte class set: 32 x 8 membership bitmap with word-serial count and run search.
// Depends on bcs_pkg.
//
// Usage: one request channel (i_in_valid / o_in_ready, payload i_in_data) and one
// result channel (o_out_valid / i_out_ready, payload o_out_data). Every request
// gives exactly one result; fields an opcode does not produce read as zero.
// Insert, remove, clear, fill, test and an empty range give their result in the
// cycle after the transfer. Insert range walks the bitmap one 8-bit word per
// cycle from the low word to the high word. Count walks all 32 words. Next run
// walks from the start word until the run ends or the top is reached. The single
// bitmap read port, one word per cycle, sets the pace of these walks; one request
// is in work at a time.
// A new request is taken while the previous result still waits in the output
// register, provided it is a scanning opcode; the other opcodes wait for the
// output register to drain.
// Reset (synchronous, active low) empties the set and drops any pending result.
// A stalled receiver holds the result register; a scan that reaches its last
// word waits there until the register can take the new result.
module byte_class_set_with_run_search (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bcs_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bcs_pkg::t_out_item  o_out_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RANGE = 5'b00010,
        S_COUNT = 5'b00100,
        S_FIND  = 5'b01000,
        S_RUN   = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    logic [bcs_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic [bcs_pkg::BYTE_W-1:0]      r_lo, r_hi;
    logic [bcs_pkg::COUNT_W-1:0]     r_acc, n_acc;
    logic [bcs_pkg::BYTE_W-1:0]      r_first, n_first;
    logic                            r_out_valid, n_out_valid;
    bcs_pkg::t_out_item              r_out, n_out;
    logic [bcs_pkg::WORD_W-1:0]      r_bits [bcs_pkg::WORDS];

    logic                            slot_free, in_fire, rng_empty, is_scan;
    logic [bcs_pkg::IDX_W-1:0]       in_w, rd_idx;
    logic [bcs_pkg::WORD_W-1:0]      word, onehot, start_mask, hits, after_f;
    logic [bcs_pkg::WORD_W-1:0]      gaps_f, gaps, rmask;
    logic [bcs_pkg::POS_W-1:0]       f_pos, zf_pos, z_pos;
    logic [bcs_pkg::COUNT_W-1:0]     sum;
    logic                            at_end;
    logic                            wr_en, clr_all, fill_all;
    logic [bcs_pkg::IDX_W-1:0]       wr_idx;
    logic [bcs_pkg::WORD_W-1:0]      wr_data;

    assign slot_free = !r_out_valid || i_out_ready;
    assign in_w      = i_in_data.byte_value[bcs_pkg::BYTE_W-1:bcs_pkg::POS_W];
    assign rng_empty = i_in_data.byte_value > i_in_data.range_high;
    assign is_scan   = (i_in_data.op == bcs_pkg::OP_RANGE && !rng_empty)
                    || i_in_data.op == bcs_pkg::OP_COUNT
                    || i_in_data.op == bcs_pkg::OP_NEXT_RUN;
    assign o_in_ready = (r_state == S_IDLE) && (slot_free || is_scan);
    assign in_fire    = i_in_valid && o_in_ready;

    // single read port: request word while idle, scan word otherwise
    assign rd_idx = (r_state == S_IDLE) ? in_w : r_idx;
    assign word   = r_bits[rd_idx] & bcs_pkg::lim_mask(rd_idx);
    assign onehot = bcs_pkg::WORD_W'(1) << i_in_data.byte_value[bcs_pkg::POS_W-1:0];
    assign at_end = (r_idx == bcs_pkg::IDX_W'(bcs_pkg::WORDS - 1));

    // run search on the current word
    assign start_mask = (r_idx == r_lo[bcs_pkg::BYTE_W-1:bcs_pkg::POS_W])
                      ? bcs_pkg::WORD_W'(8'hFF << r_lo[bcs_pkg::POS_W-1:0]) : 8'hFF;
    assign hits    = word & start_mask;
    assign f_pos   = bcs_pkg::lowest(hits);
    assign after_f = bcs_pkg::WORD_W'(8'hFE << f_pos);
    assign gaps_f  = ~word & after_f;
    assign gaps    = ~word;
    assign zf_pos  = bcs_pkg::lowest(gaps_f);
    assign z_pos   = bcs_pkg::lowest(gaps);

    assign sum = r_acc + bcs_pkg::COUNT_W'(bcs_pkg::popcount(word));

    always_comb begin
        rmask = 8'hFF;
        if (r_idx == r_lo[bcs_pkg::BYTE_W-1:bcs_pkg::POS_W]) begin
            rmask = rmask & bcs_pkg::WORD_W'(8'hFF << r_lo[bcs_pkg::POS_W-1:0]);
        end
        if (r_idx == r_hi[bcs_pkg::BYTE_W-1:bcs_pkg::POS_W]) begin
            rmask = rmask & bcs_pkg::WORD_W'(8'hFF >> (~r_hi[bcs_pkg::POS_W-1:0]));
        end
        rmask = rmask & bcs_pkg::lim_mask(r_idx);
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_first     = r_first;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_idx      = r_idx;
        wr_data     = word;
        clr_all     = 1'b0;
        fill_all    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    // a scan may start under a waiting result, which must stay intact
                    if (!is_scan) begin
                        n_out = '0;
                    end
                    unique case (i_in_data.op)
                        bcs_pkg::OP_INSERT: begin
                            wr_en       = 1'b1;
                            wr_idx      = in_w;
                            wr_data     = word | (onehot & bcs_pkg::lim_mask(in_w));
                            n_out_valid = 1'b1;
                        end
                        bcs_pkg::OP_REMOVE: begin
                            wr_en       = 1'b1;
                            wr_idx      = in_w;
                            wr_data     = word & ~onehot;
                            n_out_valid = 1'b1;
                        end
                        bcs_pkg::OP_RANGE: begin
                            if (rng_empty) begin
                                n_out_valid = 1'b1;
                            end else begin
                                n_state = S_RANGE;
                                n_idx   = in_w;
                            end
                        end
                        bcs_pkg::OP_CLEAR: begin
                            clr_all     = 1'b1;
                            n_out_valid = 1'b1;
                        end
                        bcs_pkg::OP_FILL: begin
                            fill_all    = 1'b1;
                            n_out_valid = 1'b1;
                        end
                        bcs_pkg::OP_TEST: begin
                            n_out.member = |(word & onehot);
                            n_out_valid  = 1'b1;
                        end
                        bcs_pkg::OP_COUNT: begin
                            n_state = S_COUNT;
                            n_idx   = '0;
                            n_acc   = '0;
                        end
                        bcs_pkg::OP_NEXT_RUN: begin
                            n_state = S_FIND;
                            n_idx   = in_w;
                        end
                    endcase
                end
            end

            S_RANGE: begin
                if (r_idx == r_hi[bcs_pkg::BYTE_W-1:bcs_pkg::POS_W]) begin
                    if (slot_free) begin
                        wr_en       = 1'b1;
                        wr_data     = word | rmask;
                        n_out       = '0;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    wr_en   = 1'b1;
                    wr_data = word | rmask;
                    n_idx   = r_idx + 1'b1;
                end
            end

            S_COUNT: begin
                if (at_end) begin
                    if (slot_free) begin
                        n_out              = '0;
                        n_out.member_count = sum;
                        n_out_valid        = 1'b1;
                        n_state            = S_IDLE;
                    end
                end else begin
                    n_acc = sum;
                    n_idx = r_idx + 1'b1;
                end
            end

            S_FIND: begin
                if (hits != '0) begin
                    if (gaps_f != '0 || at_end) begin
                        if (slot_free) begin
                            n_out           = '0;
                            n_out.run_found = 1'b1;
                            n_out.run_low   = {r_idx, f_pos};
                            // run ends just below the first gap, or at the top
                            n_out.run_high  = (gaps_f != '0)
                                            ? {r_idx, zf_pos} - 1'b1 : {r_idx, 3'b111};
                            n_out_valid     = 1'b1;
                            n_state         = S_IDLE;
                        end
                    end else begin
                        n_first = {r_idx, f_pos};
                        n_state = S_RUN;
                        n_idx   = r_idx + 1'b1;
                    end
                end else if (at_end) begin
                    if (slot_free) begin
                        n_out       = '0;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_RUN: begin
                if (gaps != '0 || at_end) begin
                    if (slot_free) begin
                        n_out           = '0;
                        n_out.run_found = 1'b1;
                        n_out.run_low   = r_first;
                        n_out.run_high  = (gaps != '0)
                                        ? {r_idx, z_pos} - 1'b1 : {r_idx, 3'b111};
                        n_out_valid     = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_acc   <= n_acc;
        r_first <= n_first;
        r_out   <= n_out;
        if (in_fire) begin
            r_lo <= i_in_data.byte_value;
            r_hi <= i_in_data.range_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_all) begin
            for (int i = 0; i < bcs_pkg::WORDS; i++) begin
                r_bits[i] <= '0;
            end
        end else if (fill_all) begin
            for (int i = 0; i < bcs_pkg::WORDS; i++) begin
                r_bits[i] <= bcs_pkg::lim_mask(bcs_pkg::IDX_W'(i));
            end
        end else if (wr_en) begin
            r_bits[wr_idx] <= wr_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/bcs_chk.sv]
// Port-level checks for the byte class set, bound to the top level.
// Depends on bcs_pkg and byte_class_set_with_run_search.
module bcs_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input bcs_pkg::t_in_item   i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input bcs_pkg::t_out_item  o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_reset_drop: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_no_run_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.run_found
            |-> o_out_data.run_low == 8'd0 && o_out_data.run_high == 8'd0)
        else $error("run fields set without a run");

    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.run_found |-> o_out_data.run_low <= o_out_data.run_high)
        else $error("run ends before it starts");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.member_count <= 9'd256)
        else $error("member count above set size");

endmodule

bind byte_class_set_with_run_search bcs_chk u_bcs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[tb/byte_class_set_with_run_search_checker.sv]
// Checker for the byte class set: watches both channels, keeps its own copy of
// the 256-bit membership bitmap and compares each result with its prediction.
// Depends on bcs_pkg.
module byte_class_set_with_run_search_checker
    import bcs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    logic [255:0] class_bits;
    t_out_item    expected_results[$];

    // Applies one request to the bitmap copy and returns the result it should give.
    function automatic t_out_item apply_class_op(input t_in_item req);
        t_out_item res;
        int        idx;
        int        first;
        int        top;
        int        tally;
        res   = '0;
        tally = 0;
        case (req.op)
            OP_INSERT: begin
                if (req.byte_value < LIMIT) class_bits[req.byte_value] = 1'b1;
            end
            OP_REMOVE: begin
                if (req.byte_value < LIMIT) class_bits[req.byte_value] = 1'b0;
            end
            OP_RANGE: begin
                // upper end clipped to the set size; low above high adds nothing
                top = (int'(req.range_high) >= LIMIT) ? LIMIT - 1 : int'(req.range_high);
                for (idx = int'(req.byte_value); idx <= top; idx++) class_bits[idx] = 1'b1;
            end
            OP_CLEAR: begin
                class_bits = '0;
            end
            OP_FILL: begin
                for (idx = 0; idx < LIMIT; idx++) class_bits[idx] = 1'b1;
            end
            OP_TEST: begin
                res.member = (int'(req.byte_value) < LIMIT) && class_bits[req.byte_value];
            end
            OP_COUNT: begin
                for (idx = 0; idx < LIMIT; idx++) tally += int'(class_bits[idx]);
                res.member_count = COUNT_W'(tally);
            end
            OP_NEXT_RUN: begin
                idx = int'(req.byte_value);
                while (idx < LIMIT && !class_bits[idx]) idx++;
                if (idx < LIMIT) begin
                    first = idx;
                    while (idx < LIMIT && class_bits[idx]) idx++;
                    res.run_found = 1'b1;
                    res.run_low   = BYTE_W'(first);
                    res.run_high  = BYTE_W'(idx - 1);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        o_fail_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            class_bits = '0;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            // result side first: a result leaving now belongs to an earlier request
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request waiting", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.member !== want.member)
                        report_mismatch("member", i_out_data.member, want.member);
                    if (i_out_data.member_count !== want.member_count)
                        report_mismatch("member_count", i_out_data.member_count,
                                        want.member_count);
                    if (i_out_data.run_found !== want.run_found)
                        report_mismatch("run_found", i_out_data.run_found, want.run_found);
                    if (i_out_data.run_low !== want.run_low)
                        report_mismatch("run_low", i_out_data.run_low, want.run_low);
                    if (i_out_data.run_high !== want.run_high)
                        report_mismatch("run_high", i_out_data.run_high, want.run_high);
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(apply_class_op(i_in_data));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

[tb/byte_class_set_with_run_search_tb.sv]
// Top of the byte class set testbench: clock, reset, request and result traffic
// with random idling, and the final verdict. Depends on bcs_pkg, the block and
// byte_class_set_with_run_search_checker.
module byte_class_set_with_run_search_tb;
    import bcs_pkg::*;

    localparam int MAX_GAP         = 12;
    localparam int N_PHASES        = 7;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 400000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit send_idles  = 1'b1;
    bit take_idles  = 1'b1;

    always #5 i_clk = ~i_clk;

    byte_class_set_with_run_search i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    byte_class_set_with_run_search_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int draw_gap(input bit enabled);
        return enabled ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    // Edges of the byte range come up more often than a flat draw gives.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_op pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return OP_INSERT;
        if (r < 34) return OP_REMOVE;
        if (r < 44) return OP_RANGE;
        if (r < 46) return OP_CLEAR;
        if (r < 48) return OP_FILL;
        if (r < 66) return OP_TEST;
        if (r < 74) return OP_COUNT;
        return OP_NEXT_RUN;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_request(input t_op op, input logic [7:0] lo, input logic [7:0] hi);
        int gap;
        gap = draw_gap(send_idles);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = '{op: op, byte_value: lo, range_high: hi};
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_random();
        t_op        op;
        logic [7:0] lo;
        logic [7:0] hi;
        op = pick_op();
        lo = pick_byte();
        case ($urandom_range(0, 3))
            0:       hi = lo + 8'($urandom_range(0, 7));
            1:       hi = 8'($urandom_range(0, 255));
            2:       hi = 8'd255;
            default: hi = lo - 8'd1;
        endcase
        send_request(op, lo, hi);
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
    endtask

    // Result side: random stall before each transfer.
    initial begin
        int gap;
        @(negedge i_clk);
        forever begin
            gap = draw_gap(take_idles);
            if (gap > 0) begin
                i_out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty set, single bytes at both ends, ranges, fill and clear
        send_request(OP_TEST,     8'd0,   8'd0);
        send_request(OP_COUNT,    8'd0,   8'd0);
        send_request(OP_NEXT_RUN, 8'd0,   8'd0);
        send_request(OP_INSERT,   8'd0,   8'd255);
        send_request(OP_INSERT,   8'd255, 8'd0);
        send_request(OP_TEST,     8'd0,   8'd0);
        send_request(OP_TEST,     8'd255, 8'd255);
        send_request(OP_NEXT_RUN, 8'd0,   8'd0);
        send_request(OP_NEXT_RUN, 8'd1,   8'd0);
        send_request(OP_RANGE,    8'd10,  8'd20);
        send_request(OP_RANGE,    8'd30,  8'd29);
        send_request(OP_COUNT,    8'd0,   8'd0);
        send_request(OP_NEXT_RUN, 8'd5,   8'd0);
        send_request(OP_REMOVE,   8'd15,  8'd0);
        send_request(OP_NEXT_RUN, 8'd11,  8'd0);
        send_request(OP_FILL,     8'd0,   8'd0);
        send_request(OP_COUNT,    8'd0,   8'd0);
        send_request(OP_NEXT_RUN, 8'd0,   8'd0);
        send_request(OP_REMOVE,   8'd255, 8'd0);
        send_request(OP_NEXT_RUN, 8'd255, 8'd0);
        send_request(OP_CLEAR,    8'd0,   8'd0);
        send_request(OP_RANGE,    8'd200, 8'd255);
        send_request(OP_NEXT_RUN, 8'd100, 8'd0);
        send_request(OP_RANGE,    8'd0,   8'd255);
        send_request(OP_COUNT,    8'd0,   8'd0);
        wait_drained();

        for (int phase = 0; phase < N_PHASES; phase++) begin
            send_idles = (phase % 4 == 0) || (phase % 4 == 2);
            take_idles = (phase % 4 == 0) || (phase % 4 == 3);
            repeat (ITEMS_PER_PHASE) send_random();
            // hold off until every result of the phase is out
            wait_drained();
        end
        i_in_valid = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
